// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the nearest point search checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== rtl/npis_pkg.sv =====
// ----------------------------------------------------------------------------
// npis_pkg
// shared types, widths and codes for the nearest point intensity search
// ----------------------------------------------------------------------------
package npis_pkg;

	localparam int TARGET_DEPTH  = 1024;
	localparam int IDX_W         = $clog2(TARGET_DEPTH);
	localparam int CNT_W         = $clog2(TARGET_DEPTH + 1);
	localparam int VAL_W         = 16;
	localparam int SQ_W          = 2 * VAL_W;
	localparam int DIST_W        = 37;
	localparam int MATCH_INDEX_W = 10;
	localparam int IN_DATA_W     = 4 * VAL_W;
	localparam int OUT_BITS      = MATCH_INDEX_W + DIST_W + 4 * VAL_W;
	localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W     = OUT_DATA_W - OUT_BITS;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_LOAD  = 2'd0;
	localparam mode_t MODE_QUERY = 2'd1;
	localparam mode_t MODE_CLEAR = 2'd2;

	typedef logic [1:0] metric_t;
	localparam metric_t METRIC_XYZ  = 2'd0;
	localparam metric_t METRIC_INT  = 2'd1;
	localparam metric_t METRIC_BOTH = 2'd2;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_METRIC = 2'd0;
	localparam cfg_idx_t CFG_LIMIT  = 2'd1;

	typedef logic [1:0] field_t;
	localparam field_t FIELD_X = 2'd0;
	localparam field_t FIELD_Y = 2'd1;
	localparam field_t FIELD_Z = 2'd2;
	localparam field_t FIELD_I = 2'd3;

	localparam metric_t           METRIC_RESET = METRIC_BOTH;
	localparam logic [DIST_W-1:0] LIMIT_RESET  = 37'd65536000000;

	// pos_x sits in the low bits
	typedef struct packed {
		logic [VAL_W-1:0] intensity;
		logic [VAL_W-1:0] pos_z;
		logic [VAL_W-1:0] pos_y;
		logic [VAL_W-1:0] pos_x;
	} point_t;

	function automatic logic [VAL_W-1:0] point_field(point_t p, field_t f);
		logic [VAL_W-1:0] v;
		case (f)
			FIELD_X: v = p.pos_x;
			FIELD_Y: v = p.pos_y;
			FIELD_Z: v = p.pos_z;
			default: v = p.intensity;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/nearest_point_intensity_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_point_intensity_search_unit
// brute-force nearest target search over a 1024-entry point table
// load, clear and unused-mode beats leave the unit idle and ready
// query: each of the N stored targets is scored over F fields per target
//   (3 xyz, 1 intensity, 4 both) through one squarer
// no new beat is taken while a query runs; a query accepts again once its
//   result is in the output register
// arst_n clears the table count, the control state and sets reset config
// ----------------------------------------------------------------------------
module nearest_point_intensity_search_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [npis_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // pos_x, pos_y, pos_z, intensity
	input  logic [1:0]                         s_axis_tuser,  // mode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [npis_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // match_index, match_dist_sq, match_x, match_y, match_z, match_intensity
	output logic [0:0]                         m_axis_tuser,  // found
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [npis_pkg::DIST_W-1:0]        cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                         state_q;
	logic [npis_pkg::CNT_W-1:0]         count_q;
	npis_pkg::metric_t                  metric_q;
	logic [npis_pkg::DIST_W-1:0]        limit_q;
	logic                               out_valid_q;

	npis_pkg::point_t                   mem [npis_pkg::TARGET_DEPTH];
	npis_pkg::point_t                   rd_data_q;
	npis_pkg::point_t                   query_q;
	npis_pkg::point_t                   best_pt_q;
	logic [npis_pkg::IDX_W-1:0]         j_q;
	logic [npis_pkg::IDX_W-1:0]         best_idx_q;
	logic [npis_pkg::DIST_W-1:0]        best_q;
	logic [npis_pkg::DIST_W-1:0]        acc_q;
	logic                               found_q;
	logic                               pv_q;
	npis_pkg::field_t                   f_q;
	logic [npis_pkg::OUT_DATA_W-1:0]    out_data_q;
	logic                               out_found_q;

	logic                               in_fire;
	npis_pkg::mode_t                    in_mode;
	npis_pkg::point_t                   in_pt;
	logic                               query_start;
	logic                               wr_en;
	logic                               rd_en;
	logic [npis_pkg::IDX_W-1:0]         rd_addr;
	logic [npis_pkg::IDX_W-1:0]         j_next;
	logic                               last_target;
	npis_pkg::field_t                   first_field;
	npis_pkg::field_t                   last_field;
	logic [npis_pkg::SQ_W-1:0]          prod_q;
	logic [npis_pkg::DIST_W-1:0]        sum;
	logic                               better;
	logic                               done_load;
	logic [npis_pkg::DIST_W-1:0]        out_dist;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign in_mode       = s_axis_tuser;
	assign in_pt         = npis_pkg::point_t'(s_axis_tdata);

	assign query_start = in_fire && (in_mode == npis_pkg::MODE_QUERY);
	assign wr_en       = in_fire && (in_mode == npis_pkg::MODE_LOAD)
		&& (count_q < npis_pkg::CNT_W'(npis_pkg::TARGET_DEPTH));

	assign first_field = (metric_q == npis_pkg::METRIC_INT) ? npis_pkg::FIELD_I
		: npis_pkg::FIELD_X;
	assign last_field  = (metric_q == npis_pkg::METRIC_XYZ) ? npis_pkg::FIELD_Z
		: npis_pkg::FIELD_I;

	assign j_next      = j_q + npis_pkg::IDX_W'(1);
	assign last_target = (npis_pkg::CNT_W'(j_q) + npis_pkg::CNT_W'(1)) == count_q;

	// next target is fetched while the current one is compared
	assign rd_en   = (query_start && (count_q != '0)) || ((state_q == ST_CMP) && !last_target);
	assign rd_addr = (state_q == ST_CMP) ? j_next : '0;

	assign sum    = acc_q + npis_pkg::DIST_W'(prod_q);
	assign better = sum < best_q;

	assign done_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign out_dist  = found_q ? best_q : '0;

	npis_sq_unit u_sq (
		.clk  (clk),
		.en   (state_q == ST_CALC),
		.a    (npis_pkg::point_field(query_q, f_q)),
		.b    (npis_pkg::point_field(rd_data_q, f_q)),
		.sq_q (prod_q)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[npis_pkg::IDX_W-1:0]] <= in_pt;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			metric_q    <= npis_pkg::METRIC_RESET;
			limit_q     <= npis_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					npis_pkg::CFG_METRIC: metric_q <= npis_pkg::metric_t'(cfg_data[1:0]);
					npis_pkg::CFG_LIMIT:  limit_q  <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (done_load) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: if (in_fire) begin
					case (in_mode)
						npis_pkg::MODE_LOAD: if (wr_en) begin
							count_q <= count_q + npis_pkg::CNT_W'(1);
						end
						npis_pkg::MODE_CLEAR: count_q <= '0;
						npis_pkg::MODE_QUERY: state_q <= (count_q == '0) ? ST_DONE : ST_CALC;
						default: ;
					endcase
				end
				ST_CALC: if (f_q == last_field) begin
					state_q <= ST_CMP;
				end
				ST_CMP: state_q <= last_target ? ST_DONE : ST_CALC;
				ST_DONE: if (done_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_start) begin
			query_q    <= in_pt;
			best_q     <= limit_q;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_pt_q  <= '0;
			j_q        <= '0;
		end

		if (query_start || (state_q == ST_CMP)) begin
			f_q   <= first_field;
			acc_q <= '0;
			pv_q  <= 1'b0;
		end else if (state_q == ST_CALC) begin
			if (pv_q) begin
				acc_q <= sum;
			end
			pv_q <= 1'b1;
			f_q  <= npis_pkg::field_t'(f_q + 2'd1);
		end

		if (state_q == ST_CMP) begin
			if (better) begin
				best_q     <= sum;
				best_idx_q <= j_q;
				best_pt_q  <= rd_data_q;
				found_q    <= 1'b1;
			end
			j_q <= j_next;
		end

		if (done_load) begin
			out_data_q  <= {{npis_pkg::OUT_PAD_W{1'b0}}, best_pt_q, out_dist,
				npis_pkg::MATCH_INDEX_W'(best_idx_q)};
			out_found_q <= found_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_found_q;

endmodule

// ===== rtl/npis_sq_unit.sv =====
// ----------------------------------------------------------------------------
// npis_sq_unit
// shared squared difference unit, one signed 16-bit field pair per cycle while en is high
// ----------------------------------------------------------------------------
module npis_sq_unit (
	input  logic                           clk,
	input  logic                           en,
	input  logic [npis_pkg::VAL_W-1:0]     a,
	input  logic [npis_pkg::VAL_W-1:0]     b,
	output logic [npis_pkg::SQ_W-1:0]      sq_q
);

	logic signed [npis_pkg::VAL_W:0] ax;
	logic signed [npis_pkg::VAL_W:0] bx;
	logic signed [npis_pkg::VAL_W:0] diff;
	logic [npis_pkg::VAL_W-1:0]      mag;

	assign ax   = $signed({a[npis_pkg::VAL_W-1], a});
	assign bx   = $signed({b[npis_pkg::VAL_W-1], b});
	assign diff = ax - bx;
	assign mag  = diff[npis_pkg::VAL_W] ? npis_pkg::VAL_W'(-diff)
		: diff[npis_pkg::VAL_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= npis_pkg::SQ_W'(mag) * npis_pkg::SQ_W'(mag);
		end
	end

endmodule

// ===== rtl/npis_checker.sv =====
// ----------------------------------------------------------------------------
// npis_checker
// port-level checks for the nearest point intensity search unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module npis_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [1:0]                         s_axis_tuser,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [npis_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input logic [0:0]                         m_axis_tuser
);

	// a query beat keeps the block busy for at least the next cycle
	`ASSERT_NEXT(a_query_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == npis_pkg::MODE_QUERY), !s_axis_tready)

	// a miss carries all-zero fields
	`ASSERT_IMPLY(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)

	// squared distance never exceeds four squared 16-bit spans
	`ASSERT_IMPLY(a_dist_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[46:45] == 2'b00)

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind nearest_point_intensity_search_unit npis_checker u_npis_checker (.*);
